### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, switched off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/dtdf_pkg.sv
// ----------------------------------------------------------------------------
// dtdf_pkg
// Types and constants shared by the date-time digit field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dtdf_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned NUM_FIELD = 6;
  localparam int unsigned PROD_W    = VALUE_W + 4;

  localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0]  CH_NINE   = 8'h39;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hFFFF;
  localparam logic [COUNT_W-1:0] RUN_SLOTS = 3'd6;

  // Configuration register indexes.
  localparam logic [POS_W-1:0] CFG_YEAR_POS   = 3'd0;
  localparam logic [POS_W-1:0] CFG_MONTH_POS  = 3'd1;
  localparam logic [POS_W-1:0] CFG_DAY_POS    = 3'd2;
  localparam logic [POS_W-1:0] CFG_HOUR_POS   = 3'd3;
  localparam logic [POS_W-1:0] CFG_MINUTE_POS = 3'd4;
  localparam logic [POS_W-1:0] CFG_SECOND_POS = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FEW  = 2'd1,
    STATUS_MANY = 2'd2
  } status_t;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } char_item_t;

  typedef struct packed {
    value_t [NUM_FIELD-1:0] values;
    status_t                status;
  } result_t;

endpackage

`default_nettype wire

### rtl/dtdf_cfg_regs.sv
// ----------------------------------------------------------------------------
// dtdf_cfg_regs
// Run position registers, one per output field, written over the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdf_cfg_regs
  import dtdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [POS_W-1:0]      cfg_index,
  input  wire logic [POS_W-1:0]      cfg_data,
  output pos_t [NUM_FIELD-1:0]       positions
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_FIELD; j++) begin
        positions[j] <= POS_W'(j);
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_YEAR_POS:   positions[0] <= cfg_data;
        CFG_MONTH_POS:  positions[1] <= cfg_data;
        CFG_DAY_POS:    positions[2] <= cfg_data;
        CFG_HOUR_POS:   positions[3] <= cfg_data;
        CFG_MINUTE_POS: positions[4] <= cfg_data;
        CFG_SECOND_POS: positions[5] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/dtdf_in_reg.sv
// ----------------------------------------------------------------------------
// dtdf_in_reg
// Input register for one character and the input-side handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdf_in_reg
  import dtdf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic              is_final,
  input  wire logic              out_blocked,
  output logic                   go,
  output char_item_t             item
);

  logic       held;
  char_item_t item_reg;

  // A final character needs the result register; others never wait.
  assign go       = held && !(item_reg.fin && out_blocked);
  assign in_stall = held && !go;
  assign item     = item_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (go) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_reg.ch  <= char_code;
      item_reg.fin <= is_final;
    end
  end

endmodule

`default_nettype wire

### rtl/dtdf_run_tracker.sv
// ----------------------------------------------------------------------------
// dtdf_run_tracker
// Digit accumulator, run counting and capture of the selected runs.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdf_run_tracker
  import dtdf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  go,
  input  wire char_item_t            item,
  input  wire pos_t [NUM_FIELD-1:0]  positions,
  output result_t                    result
);

  value_t                 acc;
  logic                   inside_run;
  logic [COUNT_W-1:0]     run_count;
  logic                   too_many_runs;
  value_t [NUM_FIELD-1:0] field_val;
  logic   [NUM_FIELD-1:0] field_hit;

  logic                   is_digit;
  logic [PROD_W-1:0]      prod;
  value_t                 acc_step;
  logic                   closing;
  value_t                 close_val;
  logic                   store;
  logic [NUM_FIELD-1:0]   hit_now;
  logic [COUNT_W-1:0]     count_after;

  always_comb begin
    is_digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
    prod     = (PROD_W'(acc) << 3) + (PROD_W'(acc) << 1) + PROD_W'(item.ch[3:0]);
    acc_step = (prod > PROD_W'(VALUE_MAX)) ? VALUE_MAX : prod[VALUE_W-1:0];

    // A digit closes its run only when it is the last character; a non-digit
    // closes whatever run was open.
    closing   = is_digit ? item.fin : inside_run;
    close_val = is_digit ? acc_step : acc;
    store     = closing && (run_count < RUN_SLOTS);

    for (int j = 0; j < NUM_FIELD; j++) begin
      hit_now[j] = store && (positions[j] == run_count);
    end
    count_after = run_count + COUNT_W'(store);

    for (int j = 0; j < NUM_FIELD; j++) begin
      if (hit_now[j]) begin
        result.values[j] = close_val;
      end else if (field_hit[j]) begin
        result.values[j] = field_val[j];
      end else begin
        result.values[j] = '0;
      end
    end

    if (too_many_runs || (closing && !store)) begin
      result.status = STATUS_MANY;
    end else if (count_after < RUN_SLOTS) begin
      result.status = STATUS_FEW;
    end else begin
      result.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      inside_run    <= 1'b0;
      run_count     <= '0;
      too_many_runs <= 1'b0;
      field_hit     <= '0;
    end else if (go) begin
      if (item.fin) begin
        acc           <= '0;
        inside_run    <= 1'b0;
        run_count     <= '0;
        too_many_runs <= 1'b0;
        field_hit     <= '0;
      end else begin
        acc        <= is_digit ? acc_step : '0;
        inside_run <= is_digit;
        run_count  <= count_after;
        field_hit  <= field_hit | hit_now;
        if (closing && !store) begin
          too_many_runs <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_FIELD; j++) begin
      if (go && hit_now[j]) begin
        field_val[j] <= close_val;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/dtdf_out_reg.sv
// ----------------------------------------------------------------------------
// dtdf_out_reg
// Result register holding one parsed date-time until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdf_out_reg
  import dtdf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t result,
  output logic         out_blocked,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      held
);

  assign out_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

### rtl/datetime_digit_field_parser.sv
// ----------------------------------------------------------------------------
// datetime_digit_field_parser
// Splits a date-time text into decimal digit runs and returns six fields.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle and keeps taking characters
// while a finished result waits on the output; only a final character that
// arrives while the result register is still full and stalled holds the input.
// Each character passes through an input register and then combinational
// accumulate-and-capture logic; for a final character the result is then
// loaded into the result register and held on the output until it is taken.
// Run values above 65535 saturate to 65535, and the status tells whether the
// text had fewer or more than six digit runs. The user must write position
// registers only between texts; the block itself does not enforce it.
`default_nettype none

module datetime_digit_field_parser
  import dtdf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [POS_W-1:0]   cfg_index,
  input  wire logic [POS_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CHAR_W-1:0]  char_code,
  input  wire logic               is_final,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [VALUE_W-1:0]      year_value,
  output logic [VALUE_W-1:0]      month_value,
  output logic [VALUE_W-1:0]      day_value,
  output logic [VALUE_W-1:0]      hour_value,
  output logic [VALUE_W-1:0]      minute_value,
  output logic [VALUE_W-1:0]      second_value,
  output logic [1:0]              parse_status
);

  pos_t [NUM_FIELD-1:0] positions;
  char_item_t           item;
  logic                 go;
  logic                 out_blocked;
  result_t              result;
  result_t              held;

  dtdf_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .positions (positions)
  );

  dtdf_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .is_final    (is_final),
    .out_blocked (out_blocked),
    .go          (go),
    .item        (item)
  );

  dtdf_run_tracker u_run_tracker (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .item      (item),
    .positions (positions),
    .result    (result)
  );

  dtdf_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (go && item.fin),
    .result      (result),
    .out_blocked (out_blocked),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .held        (held)
  );

  assign year_value   = held.values[0];
  assign month_value  = held.values[1];
  assign day_value    = held.values[2];
  assign hour_value   = held.values[3];
  assign minute_value = held.values[4];
  assign second_value = held.values[5];
  assign parse_status = held.status;

endmodule

`default_nettype wire

### rtl/dtdf_checker.sv
// ----------------------------------------------------------------------------
// dtdf_checker
// Port-level checks on the date-time digit field parser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dtdf_checker
  import dtdf_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              is_final,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [1:0]        parse_status,
  input wire logic [VALUE_W-1:0] year_value
);

  // A result that is not taken stays on the port.
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(year_value), "result dropped or changed while stalled")

  // The input waits only behind a full, stalled result register.
  `ASSERT_CLK(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a blocked result")

  // A fresh result must follow an accepted final character.
  `ASSERT_CLK(a_result_source, $rose(out_valid) |-> $past(in_valid && !in_stall && is_final, 2), "result without a final character")

  // out_valid is unknown until the first reset edge, so reset masks the check.
  `ASSERT_ALWAYS(a_status_code, rst || !out_valid || parse_status <= STATUS_MANY, "unknown status code")

endmodule

bind datetime_digit_field_parser dtdf_checker u_dtdf_checker (.*);

`default_nettype wire
